/* rtl/weca_pkg.sv */
// Package with payload types, widths and register indexes of the energy counter accumulator.
package weca_pkg;

  localparam int ENERGY_W       = 64;
  localparam int SOCKET_W       = 2;
  localparam int SIU_W          = 3;
  localparam int CFG_INDEX_W    = 3;
  localparam int NUM_RANGE_REGS = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RANGE_SOCKET0  = 3'd0,
    CFG_RANGE_SOCKET1  = 3'd1,
    CFG_RANGE_SOCKET2  = 3'd2,
    CFG_RANGE_SOCKET3  = 3'd3,
    CFG_SOCKETS_IN_USE = 3'd4,
    CFG_DRAM_ENABLED   = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [SOCKET_W-1:0] socket;
    logic                dram_domain;
    logic [ENERGY_W-1:0] raw_energy;
    logic                end_of_snapshot;
  } weca_in_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] package_total;
    logic [ENERGY_W-1:0] dram_energy_total;
  } weca_out_t;

endpackage

/* rtl/wrapping_energy_counter_accumulator.sv */
// Top level of the wrap-aware energy counter accumulator.
// A snapshot result passes the stage 1, stage 2 and output registers before out_valid.
// Throughput: one request per cycle; input stalls only while a snapshot result reaches
//   the output register and the previous result there is still held by out_ready low.
// Reset (rst, synchronous): clears seen flags, sums, valids; resets config registers;
//   the per-channel RAMs are not cleared, the seen flags mask their contents.
module wrapping_energy_counter_accumulator #(
  parameter int SOCKETS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  weca_pkg::weca_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output weca_pkg::weca_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [weca_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [weca_pkg::ENERGY_W-1:0]       cfg_data
);
  import weca_pkg::*;

  localparam int CHANNELS = 2 * SOCKETS;
  localparam int CH_W     = $clog2(CHANNELS);
  localparam logic [SIU_W-1:0] SOCKET_LIMIT = SIU_W'(SOCKETS);

  // configuration registers
  logic [ENERGY_W-1:0] range_reg [NUM_RANGE_REGS];
  logic [SIU_W-1:0]    sockets_in_use;
  logic                dram_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_RANGE_REGS; i++) begin
        range_reg[i] <= '0;
      end
      sockets_in_use <= SIU_W'(1);
      dram_enabled   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_SOCKET0:  range_reg[0]   <= cfg_data;
        CFG_RANGE_SOCKET1:  range_reg[1]   <= cfg_data;
        CFG_RANGE_SOCKET2:  range_reg[2]   <= cfg_data;
        CFG_RANGE_SOCKET3:  range_reg[3]   <= cfg_data;
        CFG_SOCKETS_IN_USE: sockets_in_use <= cfg_data[SIU_W-1:0];
        CFG_DRAM_ENABLED:   dram_enabled   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv;
  logic in_take;

  // stage 0: channel decode, previous-raw read and write in the same cycle
  logic [CH_W-1:0]     in_ch;
  logic                in_hit;
  logic [ENERGY_W-1:0] in_range;
  logic [ENERGY_W-1:0] prev_rd;
  logic [CHANNELS-1:0] seen;

  assign in_take = in_valid && in_ready;
  assign in_ch   = CH_W'({in_data.socket, in_data.dram_domain});
  assign in_hit  = ({1'b0, in_data.socket} < sockets_in_use) &&
                   ({1'b0, in_data.socket} < SOCKET_LIMIT) &&
                   (!in_data.dram_domain || dram_enabled);
  // DRAM channels never unwrap
  assign in_range = in_data.dram_domain ? '0 : range_reg[in_data.socket];

  // read returns the value before this write, i.e. the previous raw of the channel
  weca_ram #(
    .WIDTH (ENERGY_W),
    .DEPTH (CHANNELS)
  ) u_prev_ram (
    .clk     (clk),
    .wr_en   (in_take && in_hit),
    .wr_addr (in_ch),
    .wr_data (in_data.raw_energy),
    .rd_en   (in_take),
    .rd_addr (in_ch),
    .rd_data (prev_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (in_take && in_hit) begin
      seen[in_ch] <= 1'b1;
    end
  end

  // stage 1: delta
  logic                s1_valid;
  logic                s1_hit;
  logic                s1_dram;
  logic                s1_eos;
  logic                s1_seen;
  logic [CH_W-1:0]     s1_ch;
  logic [ENERGY_W-1:0] s1_raw;
  logic [ENERGY_W-1:0] s1_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_hit   <= in_hit;
      s1_dram  <= in_data.dram_domain;
      s1_eos   <= in_data.end_of_snapshot;
      s1_seen  <= seen[in_ch];
      s1_ch    <= in_ch;
      s1_raw   <= in_data.raw_energy;
      s1_range <= in_range;
    end
  end

  logic [ENERGY_W-1:0] fwd_delta;
  logic [ENERGY_W-1:0] wrap_delta;
  logic                no_wrap;
  logic [ENERGY_W-1:0] s1_inc;

  assign fwd_delta  = s1_raw - prev_rd;
  assign wrap_delta = s1_range - prev_rd + s1_raw;
  assign no_wrap    = (s1_range == '0) || (prev_rd > s1_range);

  // first reading of a channel loads the raw value as total
  always_comb begin
    if (!s1_seen) begin
      s1_inc = s1_raw;
    end else if (s1_raw >= prev_rd) begin
      s1_inc = fwd_delta;
    end else if (no_wrap) begin
      s1_inc = '0;
    end else begin
      s1_inc = wrap_delta;
    end
  end

  // stage 2: total update and sums
  logic                s2_valid;
  logic                s2_hit;
  logic                s2_dram;
  logic                s2_eos;
  logic                s2_seen;
  logic [CH_W-1:0]     s2_ch;
  logic [ENERGY_W-1:0] s2_inc;
  logic [ENERGY_W-1:0] tot_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_hit  <= s1_hit;
      s2_dram <= s1_dram;
      s2_eos  <= s1_eos;
      s2_seen <= s1_seen;
      s2_ch   <= s1_ch;
      s2_inc  <= s1_inc;
    end
  end

  logic                tot_we;
  logic [ENERGY_W-1:0] old_total;
  logic [ENERGY_W-1:0] new_total;
  logic                w_valid;
  logic [CH_W-1:0]     w_ch;
  logic [ENERGY_W-1:0] w_data;

  assign tot_we = adv && s2_valid && s2_hit;

  weca_ram #(
    .WIDTH (ENERGY_W),
    .DEPTH (CHANNELS)
  ) u_total_ram (
    .clk     (clk),
    .wr_en   (tot_we),
    .wr_addr (s2_ch),
    .wr_data (new_total),
    .rd_en   (adv),
    .rd_addr (s1_ch),
    .rd_data (tot_rd)
  );

  // the write from the previous step lands together with this item's read: bypass it
  assign old_total = (w_valid && (w_ch == s2_ch)) ? w_data : tot_rd;
  assign new_total = s2_seen ? (old_total + s2_inc) : s2_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (adv) begin
      w_valid <= tot_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_ch   <= s2_ch;
      w_data <= new_total;
    end
  end

  logic [ENERGY_W-1:0] package_sum;
  logic [ENERGY_W-1:0] dram_sum;
  logic [ENERGY_W-1:0] package_sum_next;
  logic [ENERGY_W-1:0] dram_sum_next;

  assign package_sum_next = package_sum + ((s2_hit && !s2_dram) ? s2_inc : '0);
  assign dram_sum_next    = dram_sum + ((s2_hit && s2_dram) ? s2_inc : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      package_sum <= '0;
      dram_sum    <= '0;
    end else if (adv && s2_valid) begin
      package_sum <= package_sum_next;
      dram_sum    <= dram_sum_next;
    end
  end

  // output register; hold the pipeline only when a new result cannot enter it
  logic out_load;

  assign adv      = !(s2_valid && s2_eos && out_valid && !out_ready);
  assign in_ready = adv;
  assign out_load = adv && s2_valid && s2_eos;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.package_total     <= package_sum_next;
      out_data.dram_energy_total <= dram_sum_next;
    end
  end

endmodule

/* rtl/weca_ram.sv */
// Generic single-write, single-read RAM with registered read data (read returns old data).
module weca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/weca_checker.sv */
// Port-level checker for the energy counter accumulator and its bind.
module weca_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input weca_pkg::weca_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input weca_pkg::weca_out_t out_data
);
  import weca_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while held");

  // a result leaves only by a taken request
  a_out_leave: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without out_ready");

  // input stalls only behind a blocked output
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wrapping_energy_counter_accumulator weca_checker u_weca_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the wrap-aware energy counter accumulator.
module testbench;
  import weca_pkg::*;

  localparam int SOCKET_COUNT   = 4;
  localparam int CHANNELS       = 2 * SOCKET_COUNT;
  localparam int PIPE_SETTLE    = 4;
  localparam int TAIL_CYCLES    = 6;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_READINGS = 150;
  localparam int BACKLOG_AFTER  = 400;
  localparam int BACKLOG_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [ENERGY_W-1:0] E_MAX = '1;

  typedef struct {
    logic                   is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [ENERGY_W-1:0]    val;
    weca_in_t               rd;
    logic                   known;
    weca_out_t              want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  weca_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  weca_out_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ENERGY_W-1:0]    cfg_data = '0;

  // Shadow registers and channel state of the predictor.
  logic [ENERGY_W-1:0] range_q [NUM_RANGE_REGS];
  logic [SIU_W-1:0]    siu_q;
  logic                dram_en_q;
  logic [ENERGY_W-1:0] chan_prev  [CHANNELS];
  logic                chan_seen  [CHANNELS];
  logic [ENERGY_W-1:0] chan_total [CHANNELS];
  logic [ENERGY_W-1:0] pkg_sum;
  logic [ENERGY_W-1:0] dram_sum;

  // Stimulus-side counter values, one per channel.
  logic [ENERGY_W-1:0] counter_trail [CHANNELS];

  weca_out_t pending_snapshots [$];
  weca_out_t snap_want;
  stim_row_t plan [$];
  int        mismatches = 0;
  int        readings_taken = 0;
  int        quiet_cycles = 0;
  bit        backlog_done = 1'b0;

  wrapping_energy_counter_accumulator #(.SOCKETS(SOCKET_COUNT)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [ENERGY_W-1:0] unwrapped_step(logic [ENERGY_W-1:0] prev,
                                                          logic [ENERGY_W-1:0] cur,
                                                          logic [ENERGY_W-1:0] span);
    if (cur >= prev) return cur - prev;
    if (span == '0 || prev > span) return '0;
    return (span - prev) + cur;
  endfunction

  function automatic weca_out_t account_reading(weca_in_t r);
    logic [SIU_W-1:0]    lim;
    logic [2:0]          ch;
    logic [ENERGY_W-1:0] old_t;
    logic [ENERGY_W-1:0] new_t;
    logic [ENERGY_W-1:0] span;
    weca_out_t           res;
    lim = (siu_q > SIU_W'(SOCKET_COUNT)) ? SIU_W'(SOCKET_COUNT) : siu_q;
    if (SIU_W'(r.socket) < lim && (!r.dram_domain || dram_en_q)) begin
      ch = {r.socket, r.dram_domain};
      old_t = chan_total[ch];
      if (chan_seen[ch]) begin
        span = r.dram_domain ? '0 : range_q[r.socket];
        new_t = old_t + unwrapped_step(chan_prev[ch], r.raw_energy, span);
      end else begin
        chan_seen[ch] = 1'b1;
        new_t = r.raw_energy;
      end
      chan_prev[ch] = r.raw_energy;
      chan_total[ch] = new_t;
      if (r.dram_domain) dram_sum = dram_sum - old_t + new_t;
      else pkg_sum = pkg_sum - old_t + new_t;
    end
    res.package_total = pkg_sum;
    res.dram_energy_total = dram_sum;
    return res;
  endfunction

  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic weca_in_t random_reading();
    weca_in_t            r;
    logic [2:0]          ch;
    logic [ENERGY_W-1:0] lim;
    logic [ENERGY_W-1:0] nxt;
    int                  live;
    live = (siu_q > SIU_W'(SOCKET_COUNT)) ? SOCKET_COUNT : int'(siu_q);
    // Aim most requests at sockets in use so the channels keep moving.
    if (live > 0 && $urandom_range(0, 9) < 8) r.socket = SOCKET_W'($urandom_range(0, live - 1));
    else r.socket = SOCKET_W'($urandom_range(0, 3));
    r.dram_domain = 1'($urandom_range(0, 1));
    r.end_of_snapshot = ($urandom_range(0, 3) == 0);
    ch = {r.socket, r.dram_domain};
    lim = (r.dram_domain || range_q[r.socket] == '0) ? 64'h0000_0000_FFFF_FFFF
                                                     : range_q[r.socket];
    case ($urandom_range(0, 19))
      0: r.raw_energy = {$urandom, $urandom};
      1: r.raw_energy = '0;
      default: begin
        // Advance the counter; fold it back past the range to force a wrap.
        nxt = counter_trail[ch] + ENERGY_W'($urandom_range(0, 5000));
        if (nxt > lim) nxt = nxt - lim;
        r.raw_energy = nxt;
      end
    endcase
    counter_trail[ch] = r.raw_energy;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [ENERGY_W-1:0] val);
    stim_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, val: val, rd: '0, known: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t rd_row(logic [1:0] s, logic d, logic [ENERGY_W-1:0] raw,
                                       logic eos);
    stim_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, val: '0, rd: '{s, d, raw, eos}, known: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t rd_known(logic [1:0] s, logic d, logic [ENERGY_W-1:0] raw,
                                         logic [ENERGY_W-1:0] pkg, logic [ENERGY_W-1:0] drm);
    stim_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, val: '0, rd: '{s, d, raw, 1'b1}, known: 1'b1,
            want: '{pkg, drm}};
    return row;
  endfunction

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [ENERGY_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_RANGE_SOCKET0, CFG_RANGE_SOCKET1,
      CFG_RANGE_SOCKET2, CFG_RANGE_SOCKET3: range_q[idx[1:0]] = val;
      CFG_SOCKETS_IN_USE: siu_q = val[SIU_W-1:0];
      CFG_DRAM_ENABLED: dram_en_q = val[0];
      default: ;
    endcase
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk);
    // Let a trailing request with no snapshot leave the pipe.
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic offer_reading(weca_in_t r, logic known, weca_out_t typed);
    int        gap;
    weca_out_t want;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    want = account_reading(r);
    readings_taken++;
    if (r.end_of_snapshot) pending_snapshots = {pending_snapshots, (known ? typed : want)};
  endtask

  task automatic load_phase(int p);
    logic [ENERGY_W-1:0] span;
    logic [SIU_W-1:0]    siu;
    logic                den;
    drain_pipeline();
    for (int s = 0; s < NUM_RANGE_REGS; s++) begin
      case (p)
        0: span = {32'h0, $urandom};
        1: span = '0;
        2: span = E_MAX;
        3: span = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
        4: span = {24'h0, 8'($urandom), $urandom};
        default: span = {$urandom, $urandom};
      endcase
      write_register(CFG_RANGE_SOCKET0 + CFG_INDEX_W'(s), span);
    end
    case (p)
      1: begin siu = 3'd2; den = 1'b1; end
      2: begin siu = 3'd4; den = 1'b0; end
      3: begin siu = SIU_W'($urandom_range(2, 7)); den = 1'($urandom_range(0, 1)); end
      4: begin siu = 3'd1; den = 1'b1; end
      default: begin siu = 3'd4; den = 1'b1; end
    endcase
    write_register(CFG_SOCKETS_IN_USE, ENERGY_W'(siu));
    write_register(CFG_DRAM_ENABLED, ENERGY_W'(den));
    cfg_we <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NUM_RANGE_REGS; i++) range_q[i] = '0;
    siu_q = 3'd1;
    dram_en_q = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      chan_prev[i] = '0;
      chan_seen[i] = 1'b0;
      chan_total[i] = '0;
      counter_trail[i] = '0;
    end
    pkg_sum = '0;
    dram_sum = '0;

    plan = {
      rd_known(2'd0, 1'b0, 64'd100, 64'd100, 64'd0),    // first reading sets the total
      rd_known(2'd0, 1'b1, 64'd50, 64'd100, 64'd0),     // DRAM disabled
      rd_known(2'd1, 1'b0, 64'd77, 64'd100, 64'd0),     // socket not in use
      rd_known(2'd0, 1'b0, 64'd40, 64'd100, 64'd0),     // backwards with range zero
      rd_row(2'd0, 1'b0, 64'd0, 1'b0),                  // failed read
      rd_known(2'd0, 1'b0, 64'd60, 64'd160, 64'd0),
      cfg_row(CFG_RANGE_SOCKET0, 64'd1000),
      cfg_row(CFG_SOCKETS_IN_USE, 64'd4),
      cfg_row(CFG_DRAM_ENABLED, 64'd1),
      rd_row(2'd0, 1'b0, 64'd900, 1'b0),
      rd_known(2'd0, 1'b0, 64'd100, 64'd1200, 64'd0),   // wrap against the range
      rd_row(2'd0, 1'b0, 64'd2000, 1'b0),
      rd_known(2'd0, 1'b0, 64'd5, 64'd3100, 64'd0),     // previous above the range
      rd_row(2'd3, 1'b1, E_MAX, 1'b0),
      rd_known(2'd3, 1'b1, 64'd1, 64'd3100, E_MAX),     // DRAM never wraps
      rd_known(2'd2, 1'b1, 64'd2, 64'd3100, 64'd1),     // DRAM sum rolls over
      cfg_row(CFG_RANGE_SOCKET3, E_MAX),
      rd_row(2'd3, 1'b0, E_MAX, 1'b0),
      rd_row(2'd3, 1'b0, 64'd0, 1'b1),
      rd_row(2'd3, 1'b0, 64'h8000_0000_0000_0000, 1'b1),
      cfg_row(CFG_RANGE_SOCKET1, E_MAX),
      cfg_row(CFG_RANGE_SOCKET2, 64'h0000_0001_0000_0000),
      rd_row(2'd1, 1'b0, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0),
      rd_row(2'd1, 1'b0, 64'h20, 1'b1),
      rd_row(2'd2, 1'b0, 64'd10, 1'b0),
      rd_row(2'd2, 1'b0, 64'd5, 1'b1),
      cfg_row(CFG_SOCKETS_IN_USE, 64'd0),
      rd_row(2'd0, 1'b0, 64'd123, 1'b1),                // no socket in use
      cfg_row(CFG_SOCKETS_IN_USE, 64'd7),               // saturates to all sockets
      cfg_row(CFG_DRAM_ENABLED, 64'd0),
      cfg_row(CFG_SPARE_LO, E_MAX),
      cfg_row(CFG_SPARE_HI, E_MAX),
      rd_row(2'd3, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1),
      rd_row(2'd1, 1'b1, 64'd5, 1'b1)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) drain_pipeline();
        write_register(plan[i].idx, plan[i].val);
        if (i + 1 >= plan.size() || !plan[i+1].is_cfg) cfg_we <= 1'b0;
      end else begin
        offer_reading(plan[i].rd, plan[i].known, plan[i].want);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_phase(p);
      repeat (PHASE_READINGS) offer_reading(random_reading(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: bursts of ready with random stalls, plus one long backlog.
  initial begin : snapshot_sink
    int run;
    int gap;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      @(posedge clk);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (!backlog_done && readings_taken >= BACKLOG_AFTER) begin
        backlog_done = 1'b1;
        out_ready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(posedge clk);
      end else begin
        gap = idle_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_snapshots.size() == 0) begin
        $error("snapshot result with none pending: package_total %h dram_energy_total %h",
               out_data.package_total, out_data.dram_energy_total);
        mismatches++;
      end else begin
        snap_want = pending_snapshots.pop_front();
        if (out_data.package_total !== snap_want.package_total) begin
          $error("package_total: expected %h, got %h",
                 snap_want.package_total, out_data.package_total);
          mismatches++;
        end
        if (out_data.dram_energy_total !== snap_want.dram_energy_total) begin
          $error("dram_energy_total: expected %h, got %h",
                 snap_want.dram_energy_total, out_data.dram_energy_total);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no request or result moved for %0d cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
